FILE: sv/sicf_pkg.sv
// sicf_pkg: constants, result type and crc-16 byte update for the spd image crc filler
// no dependencies; imported by spd_image_crc_filler
package sicf_pkg;

  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam int          SHORT_BIT  = 7;
  localparam logic [6:0]  SHORT_END  = 7'd117;
  localparam logic [6:0]  LONG_END   = 7'd126;
  localparam logic [6:0]  LAST_INDEX = 7'd127;

  // result queue: two slots must be free before a byte is taken
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [7:0] value;
    logic [6:0] index;
    logic       last;
  } result_t;

  // one byte through the crc, msb first, no final xor
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: sv/spd_image_crc_filler.sv
// spd_image_crc_filler: passes a 128-byte spd image through and fills a blank crc
// a taken byte is written into the result queue and offered from it in order; byte 126 is
//   held to byte 127, then both are queued and sent one per cycle unless out_stall
// throughput: one byte per cycle when out_stall is low; combinational crc, 4-entry queue
// reset (rst, synchronous): position, crc and queue cleared; next byte starts an image
// depends on sicf_pkg
module spd_image_crc_filler
  import sicf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [6:0] out_index,
  output logic       image_last
);

  logic [6:0]  byte_position;
  logic [15:0] crc_accumulator;
  logic        short_coverage;
  logic [7:0]  held_byte;

  result_t             queue [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr;
  logic [Q_PTR_W-1:0]  rd_ptr;
  logic [Q_CNT_W-1:0]  count;
  logic [Q_CNT_W-1:0]  count_next;

  logic        take;
  logic        give;
  logic        short_now;
  logic [15:0] crc_base;
  logic [15:0] crc_next;
  logic        covered;
  logic        blank;
  logic [1:0]  push_n;
  result_t     res0;
  result_t     res1;

  assign take      = in_valid & ~in_stall;
  assign out_valid = (count != '0);
  assign give      = out_valid & ~out_stall;
  assign in_stall  = (count > Q_CNT_W'(Q_DEPTH - 2));

  always_comb begin
    short_now = (byte_position == '0) ? data_byte[SHORT_BIT] : short_coverage;
    crc_base  = (byte_position == '0) ? 16'h0000 : crc_accumulator;
    covered   = byte_position < (short_now ? SHORT_END : LONG_END);
    crc_next  = covered ? crc_feed(crc_base, data_byte) : crc_base;
    blank     = (held_byte == 8'h00) && (data_byte == 8'h00);
    res0      = '{value: data_byte, index: byte_position, last: 1'b0};
    res1      = '{value: data_byte, index: LAST_INDEX, last: 1'b1};
    push_n    = 2'd0;
    if (byte_position < LONG_END) begin
      push_n = 2'd1;
    end else if (byte_position == LAST_INDEX) begin
      push_n      = 2'd2;
      res0.value  = blank ? crc_next[7:0] : held_byte;
      res0.index  = LONG_END;
      res1.value  = blank ? crc_next[15:8] : data_byte;
    end
    if (!take) begin
      push_n = 2'd0;
    end
    count_next = count + Q_CNT_W'(push_n) - Q_CNT_W'(give);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      crc_accumulator <= '0;
      short_coverage  <= 1'b0;
      held_byte       <= '0;
      wr_ptr          <= '0;
      rd_ptr          <= '0;
      count           <= '0;
    end else begin
      count <= count_next;
      if (give) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      wr_ptr <= wr_ptr + Q_PTR_W'(push_n);
      if (take) begin
        byte_position   <= byte_position + 7'd1;
        short_coverage  <= short_now;
        crc_accumulator <= (byte_position == LAST_INDEX) ? 16'h0000 : crc_next;
        if (byte_position == LONG_END) begin
          held_byte <= data_byte;
        end
      end
    end
  end

  // queue storage, up to two writes per cycle
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      queue[wr_ptr] <= res0;
    end
    if (push_n == 2'd2) begin
      queue[wr_ptr + Q_PTR_W'(1)] <= res1;
    end
  end

  assign out_byte   = queue[rd_ptr].value;
  assign out_index  = queue[rd_ptr].index;
  assign image_last = queue[rd_ptr].last;

endmodule
